// ===== rtl/v2dc_pkg.sv =====
// shared constants and types for the valid 2d convolution block
// no dependencies
package v2dc_pkg;
  localparam int MAX_COLUMNS_D = 1024;
  localparam int MAX_KERNEL_D  = 5;
  localparam int PIXEL_BITS_D  = 16;
  localparam int MAX_ROWS      = 1024;
  localparam int COEF_BITS     = 16;
  localparam int SUM_BITS      = 40;
  localparam int POS_BITS      = 10;
  localparam int DIM_BITS      = 11;
  localparam int KDIM_BITS     = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_COLUMNS = 2'd0,
    REG_IMAGE_ROWS    = 2'd1,
    REG_KERNEL_COLS   = 2'd2,
    REG_KERNEL_ROWS   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                valid;
    logic [POS_BITS-1:0] out_row;
    logic [POS_BITS-1:0] out_column;
    logic                last;
    logic                size_error;
  } res_info_t;
endpackage

// ===== rtl/v2dc_mac.sv =====
// pipelined window products and adder tree
// depends on v2dc_pkg
module v2dc_mac #(
  parameter int MAX_KERNEL = v2dc_pkg::MAX_KERNEL_D
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       adv,
  input  logic signed [v2dc_pkg::PIXEL_BITS_D-1:0]   win [MAX_KERNEL*MAX_KERNEL],
  input  logic signed [v2dc_pkg::COEF_BITS-1:0]      coef [MAX_KERNEL*MAX_KERNEL],
  input  logic [MAX_KERNEL*MAX_KERNEL-1:0]           use_tap,
  input  v2dc_pkg::res_info_t                        info_in,
  output logic signed [v2dc_pkg::SUM_BITS-1:0]       sum,
  output v2dc_pkg::res_info_t                        info_out
);
  localparam int NT = MAX_KERNEL * MAX_KERNEL;
  localparam int PB = v2dc_pkg::PIXEL_BITS_D + v2dc_pkg::COEF_BITS;
  localparam int SB = v2dc_pkg::SUM_BITS;

  logic signed [PB-1:0] prod_r [NT];
  logic signed [SB-1:0] part_r [MAX_KERNEL];
  logic signed [SB-1:0] sum_r;
  v2dc_pkg::res_info_t  info1_r, info2_r, info3_r;
  logic signed [SB-1:0] part_nxt [MAX_KERNEL];
  logic signed [SB-1:0] sum_nxt;

  always_comb begin
    for (int r = 0; r < MAX_KERNEL; r++) begin
      part_nxt[r] = '0;
      for (int c = 0; c < MAX_KERNEL; c++) begin
        part_nxt[r] = part_nxt[r] + SB'(prod_r[r*MAX_KERNEL+c]);
      end
    end
    sum_nxt = '0;
    for (int r = 0; r < MAX_KERNEL; r++) begin
      sum_nxt = sum_nxt + part_r[r];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NT; i++) begin
        prod_r[i] <= use_tap[i] ? PB'(win[i]) * PB'(coef[i]) : '0;
      end
      part_r <= part_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      info1_r <= '0;
      info2_r <= '0;
      info3_r <= '0;
    end else if (adv) begin
      info1_r <= info_in;
      info2_r <= info1_r;
      info3_r <= info2_r;
    end
  end

  assign sum      = info3_r.size_error ? '0 : sum_r;
  assign info_out = info3_r;
endmodule

// ===== rtl/valid_2d_convolution_top.sv =====
// top level of the valid 2d convolution block: line buffer memory, window, kernel
// depends on v2dc_pkg and v2dc_mac
//
// usage: kernel coefficients (mode 0) and raster pixels (mode 1) enter on the
// in_ stream, one beat per clock while in_tready is high. a pixel that completes a full window gives
// one beat on the out_ stream with its sum, output row and column; the last
// result of a frame has tlast set. a kernel larger than the image gives one
// beat at the frame's last pixel with size_error set and sum zero.
// a pixel's result passes in turn through the line buffer read, product, row
// sums, total and output registers.
// throughput: one item per clock, set by the single read and write port of
// the line buffer memory, read one beat ahead and written back the next.
// the pipeline stalls as a whole when the output beat waits; in_tready drops
// only while the output register holds an untaken result.
// reset clears position, window and kernel and sets the size registers to
// 1024 x 1024 with a 3 x 3 kernel. the line buffer needs no clearing.
// the user writes configuration through cfg_ while the block is idle; unchecked.
module valid_2d_convolution_top #(
  parameter int MAX_COLUMNS = v2dc_pkg::MAX_COLUMNS_D,
  parameter int MAX_KERNEL  = v2dc_pkg::MAX_KERNEL_D
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [v2dc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [v2dc_pkg::DIM_BITS-1:0]         cfg_data,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // coef_index, coefficient, pixel, zero fill
  input  logic [v2dc_pkg::IN_DATA_BITS-1:0]     in_tdata,
  // mode, frame_start
  input  logic [1:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // sum, out_row, out_column, zero fill
  output logic [v2dc_pkg::OUT_DATA_BITS-1:0]    out_tdata,
  // size_error
  output logic                                  out_tuser,
  output logic                                  out_tlast
);
  localparam int PIXEL_BITS = v2dc_pkg::PIXEL_BITS_D;
  localparam int NT  = MAX_KERNEL * MAX_KERNEL;
  localparam int TW  = $clog2(NT);
  localparam int LB  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int KIW = 5;
  localparam int PW  = v2dc_pkg::POS_BITS;
  localparam int DW  = v2dc_pkg::DIM_BITS;
  localparam int KW  = v2dc_pkg::KDIM_BITS;
  localparam int SB  = v2dc_pkg::SUM_BITS;

  logic [DW-1:0] img_cols_r, img_rows_r;
  logic [KW-1:0] k_cols_r, k_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_cols_r <= DW'(1024);
      img_rows_r <= DW'(1024);
      k_cols_r   <= KW'(3);
      k_rows_r   <= KW'(3);
    end else if (cfg_we) begin
      case (v2dc_pkg::cfg_reg_t'(cfg_index))
        v2dc_pkg::REG_IMAGE_COLUMNS: img_cols_r <= cfg_data;
        v2dc_pkg::REG_IMAGE_ROWS:    img_rows_r <= cfg_data;
        v2dc_pkg::REG_KERNEL_COLS:   k_cols_r   <= cfg_data[KW-1:0];
        v2dc_pkg::REG_KERNEL_ROWS:   k_rows_r   <= cfg_data[KW-1:0];
        default: ;
      endcase
    end
  end

  logic [12:0] cols, rows;
  logic [KW:0] kc, kr;
  always_comb begin
    cols = (img_cols_r == '0) ? 13'd1 : (13'(img_cols_r) > 13'(MAX_COLUMNS))
           ? 13'(MAX_COLUMNS) : 13'(img_cols_r);
    rows = (img_rows_r == '0) ? 13'd1 : (13'(img_rows_r) > 13'(v2dc_pkg::MAX_ROWS))
           ? 13'(v2dc_pkg::MAX_ROWS) : 13'(img_rows_r);
    kc = (k_cols_r == '0) ? (KW+1)'(1) : ((KW+1)'(k_cols_r) > (KW+1)'(MAX_KERNEL))
         ? (KW+1)'(MAX_KERNEL) : (KW+1)'(k_cols_r);
    kr = (k_rows_r == '0) ? (KW+1)'(1) : ((KW+1)'(k_rows_r) > (KW+1)'(MAX_KERNEL))
         ? (KW+1)'(MAX_KERNEL) : (KW+1)'(k_rows_r);
  end

  // input fields
  logic                              in_mode, in_fs;
  logic [KIW-1:0]                    in_cidx;
  logic signed [v2dc_pkg::COEF_BITS-1:0] in_coef;
  logic signed [PIXEL_BITS-1:0]      in_pix;
  assign in_mode = in_tuser[0];
  assign in_fs   = in_tuser[1];
  assign in_cidx = in_tdata[4:0];
  assign in_coef = in_tdata[20:5];
  assign in_pix  = in_tdata[21 +: PIXEL_BITS];

  // pipeline advance: output register free or being taken
  logic adv;
  logic acc_in;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign acc_in    = in_tvalid && in_tready;

  // kernel store
  logic signed [v2dc_pkg::COEF_BITS-1:0] kern_r [NT];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) kern_r[i] <= '0;
    end else if (acc_in && !in_mode && 32'(in_cidx) < NT) begin
      kern_r[in_cidx] <= in_coef;
    end
  end

  // position counters, stage 0
  logic [PW-1:0] prow_r, pcol_r, row0, col0, prow_nxt, pcol_nxt;
  always_comb begin
    row0 = in_fs ? '0 : prow_r;
    col0 = in_fs ? '0 : pcol_r;
    if (13'(col0) + 13'd1 >= cols) begin
      pcol_nxt = '0;
      prow_nxt = (13'(row0) + 13'd1 >= rows) ? '0 : PW'(row0 + 1'b1);
    end else begin
      pcol_nxt = PW'(col0 + 1'b1);
      prow_nxt = prow_r;
      if (in_fs) prow_nxt = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prow_r <= '0;
      pcol_r <= '0;
    end else if (acc_in && in_mode) begin
      prow_r <= prow_nxt;
      pcol_r <= pcol_nxt;
    end
  end

  logic [CW-1:0] lc0;
  assign lc0 = (32'(col0) < MAX_COLUMNS) ? CW'(col0) : CW'(MAX_COLUMNS - 1);

  // line buffer memory: one word holds the rows above, read then written back
  localparam int LWB = LB * PIXEL_BITS;
  logic [LWB-1:0] lbuf [MAX_COLUMNS];
  logic [LWB-1:0] rd_r, wr_data;
  logic           s1_v_r;
  logic [CW-1:0]  s1_lc_r;
  logic signed [PIXEL_BITS-1:0] s1_pix_r;
  logic [PW-1:0]  s1_row_r, s1_col_r;
  logic           wb_v_r;
  logic [CW-1:0]  wb_lc_r;
  logic [LWB-1:0] wb_data_r;
  logic [LWB-1:0] rd_fwd;

  always_ff @(posedge clk) begin
    if (acc_in && in_mode) rd_r <= lbuf[lc0];
    if (s1_v_r && adv) lbuf[s1_lc_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      wb_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc_in && in_mode;
      wb_v_r <= s1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lc_r   <= lc0;
      s1_pix_r  <= in_pix;
      s1_row_r  <= row0;
      s1_col_r  <= col0;
      wb_lc_r   <= s1_lc_r;
      wb_data_r <= wr_data;
    end
  end

  // forward a write issued in the same cycle as the read of that column
  always_comb begin
    rd_fwd = (wb_v_r && wb_lc_r == s1_lc_r) ? wb_data_r : rd_r;
  end

  logic signed [PIXEL_BITS-1:0] colv [MAX_KERNEL];
  always_comb begin
    colv[0] = s1_pix_r;
    for (int r = 1; r < MAX_KERNEL; r++) colv[r] = rd_fwd[(r-1)*PIXEL_BITS +: PIXEL_BITS];
    wr_data = rd_fwd;
    if (MAX_KERNEL > 1) begin
      wr_data = LWB'({rd_fwd, s1_pix_r});
    end
  end

  // window registers
  logic signed [PIXEL_BITS-1:0] win_r [NT];
  logic signed [PIXEL_BITS-1:0] win_nxt [NT];
  always_comb begin
    for (int r = 0; r < MAX_KERNEL; r++) begin
      for (int c = MAX_KERNEL - 1; c > 0; c--) win_nxt[r*MAX_KERNEL+c] = win_r[r*MAX_KERNEL+c-1];
      win_nxt[r*MAX_KERNEL] = colv[r];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) win_r[i] <= '0;
    end else if (s1_v_r && adv) begin
      win_r <= win_nxt;
    end
  end

  // result decision and tap mapping
  v2dc_pkg::res_info_t info;
  logic signed [PIXEL_BITS-1:0] win_map [NT];
  logic signed [v2dc_pkg::COEF_BITS-1:0] coef_map [NT];
  logic [NT-1:0] use_tap;
  logic [TW-1:0] widx, cidx;
  logic at_end, too_big;
  always_comb begin
    at_end  = (13'(s1_row_r) == rows - 13'd1) && (13'(s1_col_r) == cols - 13'd1);
    too_big = (13'(kc) > cols) || (13'(kr) > rows);
    info = '0;
    if (s1_v_r) begin
      if (too_big) begin
        info.valid      = at_end;
        info.last       = 1'b1;
        info.size_error = 1'b1;
      end else if (13'(s1_row_r) + 13'd1 >= 13'(kr) && 13'(s1_col_r) + 13'd1 >= 13'(kc)) begin
        info.valid      = 1'b1;
        info.out_row    = PW'(s1_row_r - PW'(kr - 1'b1));
        info.out_column = PW'(s1_col_r - PW'(kc - 1'b1));
        info.last       = at_end;
      end
    end
    widx = '0;
    cidx = '0;
    for (int v = 0; v < MAX_KERNEL; v++) begin
      for (int u = 0; u < MAX_KERNEL; u++) begin
        use_tap[v*MAX_KERNEL+u] = (v < int'(kr)) && (u < int'(kc));
        if (use_tap[v*MAX_KERNEL+u]) begin
          widx = TW'((int'(kr) - 1 - v) * MAX_KERNEL + int'(kc) - 1 - u);
          cidx = TW'(v * int'(kc) + u);
        end else begin
          widx = '0;
          cidx = '0;
        end
        win_map[v*MAX_KERNEL+u]  = win_nxt[widx];
        coef_map[v*MAX_KERNEL+u] = kern_r[cidx];
      end
    end
  end

  logic signed [SB-1:0] sum;
  v2dc_pkg::res_info_t  info_o;
  v2dc_mac #(.MAX_KERNEL(MAX_KERNEL)) u_mac (
    .clk(clk), .rst_n(rst_n), .adv(adv), .win(win_map), .coef(coef_map),
    .use_tap(use_tap), .info_in(info), .sum(sum), .info_out(info_o)
  );

  // output register
  logic [SB-1:0]  osum_r;
  logic [PW-1:0]  orow_r, ocol_r;
  logic           olast_r, oerr_r, ovalid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (adv) ovalid_r <= info_o.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      osum_r  <= sum;
      orow_r  <= info_o.out_row;
      ocol_r  <= info_o.out_column;
      olast_r <= info_o.last;
      oerr_r  <= info_o.size_error;
    end
  end
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'b0, ocol_r, orow_r, osum_r};
  assign out_tuser  = oerr_r;
  assign out_tlast  = olast_r;
endmodule
